FILE: hdl/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg: shared definitions for the delta-list timeout queue
// Table depth, request and status codes, sequencer states and helpers.
// ----------------------------------------------------------------------------
package dltq_pkg;

    localparam int DEPTH       = 16;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int MAX_RESULTS = 16;
    localparam int K_W         = $clog2(MAX_RESULTS + 1);

    // request kinds
    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_SCHEDULE = 2'd1;
    localparam logic [1:0] REQ_CANCEL   = 2'd2;
    localparam logic [1:0] REQ_DRAIN    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EXPIRED   = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCHED_SCAN,
        S_SCHED_SHIFT,
        S_SCHED_FIX,
        S_CANCEL_SCAN,
        S_CANCEL_ADD,
        S_CANCEL_SHIFT,
        S_TICK,
        S_DRAIN_CHECK,
        S_DRAIN_SHIFT,
        S_FINISH
    } state_t;

    // clamp a 33-bit signed value into 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -33'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: hdl/delta_list_timeout_queue_unit.sv
// ----------------------------------------------------------------------------
// delta_list_timeout_queue_unit: timeout queue held as an ordered delta list
// Schedule, cancel, tick and drain requests on a table walked by a
// small sequencer.
// ----------------------------------------------------------------------------
// Usage
//   Requests come in on the s_axis channel: tuser carries the request kind,
//   tdata the tag and delay. Results leave on m_axis: tuser carries the
//   status, tdata the expired tag, lateness and due flag, tlast marks the
//   final result of a request. Tick, schedule and cancel give one result;
//   drain gives one result per due entry popped (up to 16), or one empty
//   result.
//   One table entry is visited per cycle, save while a drain waits for
//   the output register to free. The s_axis_tready is low while a
//   request is being worked on.
//   Reset empties the queue at once; the table contents are not cleared.
//   A result waits in the output register while m_axis_tready is low;
//   the next request is still taken once the table work is finished, and
//   any further result holds the sequencer until the register frees.
// ----------------------------------------------------------------------------
module delta_list_timeout_queue_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // tag[15:0], delay_ticks[46:16], zero pad
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // expired_tag[15:0], lateness[47:16],
                                        // due_waiting[48], zero pad
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);

    // table storage
    logic [15:0]        tag_mem   [dltq_pkg::DEPTH];
    logic signed [31:0] delta_mem [dltq_pkg::DEPTH];

    dltq_pkg::state_t state_reg, state_next;
    logic [dltq_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [dltq_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [dltq_pkg::CNT_W-1:0] pos_reg, pos_next;
    logic [dltq_pkg::K_W-1:0]   k_reg, k_next;
    logic [15:0]        tag_reg, tag_next;
    logic signed [31:0] t_reg, t_next;
    logic               pend_reg, pend_next;
    logic [15:0]        ptag_reg, ptag_next;
    logic signed [31:0] plate_reg, plate_next;
    logic [1:0]         rstat_reg, rstat_next;
    logic               rdue_reg, rdue_next;

    // output register
    logic               ov_reg, ov_next;
    logic [1:0]         ostat_reg, ostat_next;
    logic [15:0]        otag_reg, otag_next;
    logic signed [31:0] olate_reg, olate_next;
    logic               odue_reg, odue_next;
    logic               olast_reg, olast_next;

    // single read and write port to the table
    logic [dltq_pkg::IDX_W-1:0] rd_addr, wr_addr;
    logic [15:0]        rd_tag, wr_tag;
    logic signed [31:0] rd_delta, wr_delta;
    logic               wr_en;

    logic               out_free;
    logic signed [31:0] dec;
    logic [30:0]        in_delay;
    logic               has_due;

    assign rd_tag   = tag_mem[rd_addr];
    assign rd_delta = delta_mem[rd_addr];
    assign out_free = !ov_reg || m_axis_tready;
    assign in_delay = s_axis_tdata[46:16];
    assign dec      = dltq_pkg::sat32({rd_delta[31], rd_delta} - 33'sd1);
    assign has_due  = (k_reg < dltq_pkg::K_W'(dltq_pkg::MAX_RESULTS))
                      && (cnt_reg != '0) && (rd_delta <= 32'sd0);

    assign s_axis_tready = (state_reg == dltq_pkg::S_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = ostat_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {7'd0, odue_reg, olate_reg, otag_reg};

    // table write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[wr_addr]   <= wr_tag;
            delta_mem[wr_addr] <= wr_delta;
        end
    end

    // control and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dltq_pkg::S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            pend_reg  <= pend_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        k_reg     <= k_next;
        tag_reg   <= tag_next;
        t_reg     <= t_next;
        ptag_reg  <= ptag_next;
        plate_reg <= plate_next;
        rstat_reg <= rstat_next;
        rdue_reg  <= rdue_next;
        ostat_reg <= ostat_next;
        otag_reg  <= otag_next;
        olate_reg <= olate_next;
        odue_reg  <= odue_next;
        olast_reg <= olast_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        tag_next   = tag_reg;
        t_next     = t_reg;
        pend_next  = pend_reg;
        ptag_next  = ptag_reg;
        plate_next = plate_reg;
        rstat_next = rstat_reg;
        rdue_next  = rdue_reg;
        ov_next    = ov_reg && !m_axis_tready;
        ostat_next = ostat_reg;
        otag_next  = otag_reg;
        olate_next = olate_reg;
        odue_next  = odue_reg;
        olast_next = olast_reg;
        rd_addr    = idx_reg[dltq_pkg::IDX_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = idx_reg[dltq_pkg::IDX_W-1:0];
        wr_tag     = rd_tag;
        wr_delta   = rd_delta;

        case (state_reg)
            dltq_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    tag_next   = s_axis_tdata[15:0];
                    t_next     = (in_delay == '0) ? 32'sd1 : $signed({1'b0, in_delay});
                    idx_next   = '0;
                    k_next     = '0;
                    pend_next  = 1'b0;
                    rstat_next = dltq_pkg::ST_DONE;
                    rdue_next  = 1'b0;
                    case (s_axis_tuser)
                        dltq_pkg::REQ_TICK:     state_next = dltq_pkg::S_TICK;
                        dltq_pkg::REQ_SCHEDULE:
                        begin
                            if (cnt_reg == dltq_pkg::CNT_W'(dltq_pkg::DEPTH))
                            begin
                                rstat_next = dltq_pkg::ST_FULL;
                                state_next = dltq_pkg::S_FINISH;
                            end
                            else
                                state_next = dltq_pkg::S_SCHED_SCAN;
                        end
                        dltq_pkg::REQ_CANCEL:   state_next = dltq_pkg::S_CANCEL_SCAN;
                        default:                state_next = dltq_pkg::S_DRAIN_CHECK;
                    endcase
                end
            end

            // find insertion point, taking positive deltas off the delay
            dltq_pkg::S_SCHED_SCAN:
            begin
                if (idx_reg < cnt_reg && rd_delta < t_reg)
                begin
                    if (rd_delta > 32'sd0)
                        t_next = t_reg - rd_delta;
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    pos_next   = idx_reg;
                    idx_next   = cnt_reg;
                    state_next = dltq_pkg::S_SCHED_SHIFT;
                end
            end

            // open a gap, moving entries up one place from the tail
            dltq_pkg::S_SCHED_SHIFT:
            begin
                if (idx_reg > pos_reg)
                begin
                    rd_addr  = dltq_pkg::IDX_W'(idx_reg - 1'b1);
                    wr_en    = 1'b1;
                    idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_tag   = tag_reg;
                    wr_delta = t_reg;
                    cnt_next = cnt_reg + 1'b1;
                    if (pos_reg < cnt_reg)
                        state_next = dltq_pkg::S_SCHED_FIX;
                    else
                        state_next = dltq_pkg::S_FINISH;
                end
            end

            // successor loses the new entry's delta
            dltq_pkg::S_SCHED_FIX:
            begin
                rd_addr    = dltq_pkg::IDX_W'(pos_reg + 1'b1);
                wr_addr    = rd_addr;
                wr_en      = 1'b1;
                wr_delta   = dltq_pkg::sat32({rd_delta[31], rd_delta} - {t_reg[31], t_reg});
                state_next = dltq_pkg::S_FINISH;
            end

            // look for the first matching tag
            dltq_pkg::S_CANCEL_SCAN:
            begin
                if (idx_reg == cnt_reg)
                begin
                    rstat_next = dltq_pkg::ST_NOT_FOUND;
                    state_next = dltq_pkg::S_FINISH;
                end
                else if (rd_tag == tag_reg)
                begin
                    pos_next = idx_reg;
                    t_next   = rd_delta;
                    if (idx_reg + 1'b1 < cnt_reg && rd_delta > 32'sd0)
                        state_next = dltq_pkg::S_CANCEL_ADD;
                    else
                        state_next = dltq_pkg::S_CANCEL_SHIFT;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end

            // hand the removed delta on to the successor
            dltq_pkg::S_CANCEL_ADD:
            begin
                rd_addr    = dltq_pkg::IDX_W'(pos_reg + 1'b1);
                wr_addr    = rd_addr;
                wr_en      = 1'b1;
                wr_delta   = dltq_pkg::sat32({rd_delta[31], rd_delta} + {t_reg[31], t_reg});
                state_next = dltq_pkg::S_CANCEL_SHIFT;
            end

            // close the gap, moving entries down one place
            dltq_pkg::S_CANCEL_SHIFT:
            begin
                if (idx_reg + 1'b1 < cnt_reg)
                begin
                    rd_addr  = dltq_pkg::IDX_W'(idx_reg + 1'b1);
                    wr_en    = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = dltq_pkg::S_FINISH;
                end
            end

            // age due entries and the first pending one
            dltq_pkg::S_TICK:
            begin
                if (idx_reg == cnt_reg)
                    state_next = dltq_pkg::S_FINISH;
                else
                begin
                    wr_en    = 1'b1;
                    wr_delta = dec;
                    if (dec > 32'sd0)
                        state_next = dltq_pkg::S_FINISH;
                    else
                    begin
                        rdue_next = 1'b1;
                        if (dec == 32'sd0)
                            state_next = dltq_pkg::S_FINISH;
                        else
                            idx_next = idx_reg + 1'b1;
                    end
                end
            end

            // one due entry is held back so its tlast is known
            dltq_pkg::S_DRAIN_CHECK:
            begin
                rd_addr = '0;
                if (has_due)
                begin
                    if (!pend_reg || out_free)
                    begin
                        if (pend_reg)
                        begin
                            ov_next    = 1'b1;
                            ostat_next = dltq_pkg::ST_EXPIRED;
                            otag_next  = ptag_reg;
                            olate_next = plate_reg;
                            odue_next  = 1'b0;
                            olast_next = 1'b0;
                        end
                        pend_next  = 1'b1;
                        ptag_next  = rd_tag;
                        plate_next = rd_delta;
                        k_next     = k_reg + 1'b1;
                        idx_next   = '0;
                        state_next = dltq_pkg::S_DRAIN_SHIFT;
                    end
                end
                else
                begin
                    if (pend_reg)
                        rstat_next = dltq_pkg::ST_EXPIRED;
                    state_next = dltq_pkg::S_FINISH;
                end
            end

            // pop the front entry
            dltq_pkg::S_DRAIN_SHIFT:
            begin
                if (idx_reg + 1'b1 < cnt_reg)
                begin
                    rd_addr  = dltq_pkg::IDX_W'(idx_reg + 1'b1);
                    wr_en    = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = dltq_pkg::S_DRAIN_CHECK;
                end
            end

            // final result of the request
            dltq_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ostat_next = rstat_reg;
                    otag_next  = pend_reg ? ptag_reg : 16'd0;
                    olate_next = pend_reg ? plate_reg : 32'sd0;
                    odue_next  = rdue_reg;
                    olast_next = 1'b1;
                    pend_next  = 1'b0;
                    state_next = dltq_pkg::S_IDLE;
                end
            end

            default:
                state_next = dltq_pkg::S_IDLE;
        endcase
    end

endmodule
